/* rtl/core/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions of the text console writer
// Screen geometry, character codes, command and state types.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int SCREEN_WIDTH  = 80;
	localparam int SCREEN_HEIGHT = 25;
	localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;

	localparam int MEM_AW  = $clog2(CELL_COUNT);
	localparam int ADDR_W  = 11;
	localparam int ROW_W   = 5;
	localparam int COL_W   = 7;
	localparam int CELL_W  = 16;
	localparam int CHAR_W  = 8;
	localparam int ATTR_W  = 8;
	localparam int MODE_W  = 2;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_ATTR = 1'b0;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
	localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
	localparam logic [ATTR_W-1:0] DEFAULT_ATTR = 8'h02;

	// A tab stop every four columns: the two low column bits.
	localparam logic [1:0] TAB_LAST_COL = 2'b11;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_CHAR,
		OP_NEWLINE,
		OP_RETURN,
		OP_TAB,
		OP_READ,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [CHAR_W-1:0] char_code;
		logic [MEM_AW-1:0] addr;
		logic              addr_ok;
	} cmd_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_RETURN,
		S_WRAP,
		S_NEWLINE,
		S_PUT,
		S_TAB,
		S_SCROLL_CP,
		S_SCROLL_DR,
		S_SCROLL_BL,
		S_CLEAR,
		S_READ,
		S_DONE
	} bstate_t;

	typedef struct packed {
		logic              we;
		logic [ATTR_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic              init_busy;
		logic [ATTR_W-1:0] attr;
	} back_status_t;

endpackage

/* rtl/core/tcw_front.sv */
// ----------------------------------------------------------------------------
// tcw_front: input side of the text console writer
// Accepts items and turns each into a decoded command for the queue.
// ----------------------------------------------------------------------------
module tcw_front (
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            mode,
	input  logic [7:0]            char_code,
	input  logic [10:0]           cell_address,
	input  tcw_pkg::back_status_t status,
	input  logic                  q_full,
	output logic                  q_push,
	output tcw_pkg::cmd_t         q_cmd
);
	import tcw_pkg::*;

	op_t op;

	always_comb begin
		case (mode)
			MODE_PUT: begin
				if (char_code == CH_NEWLINE) begin
					op = OP_NEWLINE;
				end else if (char_code == CH_RETURN) begin
					op = OP_RETURN;
				end else if (char_code == CH_TAB) begin
					op = OP_TAB;
				end else begin
					op = OP_CHAR;
				end
			end
			MODE_READ:  op = OP_READ;
			MODE_CLEAR: op = OP_CLEAR;
			default:    op = OP_NOP;
		endcase
	end

	// Nothing is taken while the store is being cleared after reset.
	assign in_stall = q_full | status.init_busy;
	assign q_push   = in_valid & ~in_stall;

	assign q_cmd.op        = op;
	assign q_cmd.char_code = char_code;
	assign q_cmd.addr      = MEM_AW'(cell_address);
	assign q_cmd.addr_ok   = ({1'b0, cell_address} < (ADDR_W + 1)'(CELL_COUNT));

endmodule

/* rtl/core/tcw_queue.sv */
// ----------------------------------------------------------------------------
// tcw_queue: command queue of the text console writer
// A short register queue between the front and the back.
// ----------------------------------------------------------------------------
module tcw_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tcw_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          valid,
	output logic          full,
	output tcw_pkg::cmd_t head_cmd
);
	import tcw_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign valid    = (count_q != '0);
	assign full     = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign head_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

/* rtl/core/tcw_back.sv */
// ----------------------------------------------------------------------------
// tcw_back: execution side of the text console writer
// Owns the screen store, cursor and attribute, and the result register.
// ----------------------------------------------------------------------------
module tcw_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  tcw_pkg::cmd_t         q_cmd,
	output logic                  q_pop,
	input  tcw_pkg::cfg_wr_t      cfg,
	output tcw_pkg::back_status_t status,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [15:0]           cell_value,
	output logic [4:0]            cursor_row,
	output logic [6:0]            cursor_col,
	output logic                  scrolled
);
	import tcw_pkg::*;

	localparam logic [MEM_AW-1:0] LAST_CELL = MEM_AW'(CELL_COUNT - 1);
	localparam logic [MEM_AW-1:0] ROW_STEP  = MEM_AW'(SCREEN_WIDTH);
	localparam logic [MEM_AW-1:0] LAST_ROW_BASE = MEM_AW'(CELL_COUNT - SCREEN_WIDTH);
	localparam logic [COL_W-1:0]  COL_EDGE  = COL_W'(SCREEN_WIDTH);
	localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(SCREEN_HEIGHT - 1);

	logic [CELL_W-1:0] mem [CELL_COUNT];

	bstate_t           state_q;
	bstate_t           state_next;
	bstate_t           resume_state;

	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [MEM_AW-1:0] row_base_q;
	logic [ATTR_W-1:0] attr_q;
	logic [MEM_AW-1:0] ptr_q;

	op_t               op_q;
	logic [CHAR_W-1:0] ch_q;
	logic [MEM_AW-1:0] addr_q;
	logic              addr_ok_q;
	logic              scrolled_q;

	logic [CELL_W-1:0] rdata_q;
	logic              pend_s1;
	logic [MEM_AW-1:0] waddr_s1;

	logic              out_valid_q;
	logic [CELL_W-1:0] out_cell_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [COL_W-1:0]  out_col_q;
	logic              out_scr_q;

	logic              mem_we;
	logic [MEM_AW-1:0] mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic              mem_re;
	logic [MEM_AW-1:0] mem_raddr;
	logic              out_load;
	logic [MEM_AW-1:0] cursor_idx;
	logic              at_edge;
	logic              tab_stop;

	assign cursor_idx = row_base_q + MEM_AW'(col_q);
	assign at_edge    = (col_q >= COL_EDGE);
	assign tab_stop   = at_edge || (col_q[1:0] == TAB_LAST_COL);

	// Where a pending new line hands back once the cursor has moved.
	always_comb begin
		case (op_q)
			OP_NEWLINE: resume_state = S_DONE;
			OP_TAB:     resume_state = S_TAB;
			default:    resume_state = S_PUT;
		endcase
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			S_INIT: begin
				if (ptr_q == LAST_CELL) begin
					state_next = S_IDLE;
				end
			end
			S_IDLE: begin
				if (q_valid) begin
					case (q_cmd.op)
						OP_NEWLINE:      state_next = S_NEWLINE;
						OP_RETURN:       state_next = S_RETURN;
						OP_CHAR, OP_TAB: state_next = S_WRAP;
						OP_READ:         state_next = q_cmd.addr_ok ? S_READ : S_DONE;
						OP_CLEAR:        state_next = S_CLEAR;
						default:         state_next = S_DONE;
					endcase
				end
			end
			S_RETURN: state_next = S_DONE;
			S_WRAP: begin
				if (at_edge) begin
					state_next = S_NEWLINE;
				end else begin
					state_next = (op_q == OP_TAB) ? S_TAB : S_PUT;
				end
			end
			S_NEWLINE: begin
				state_next = (row_q < ROW_LAST) ? resume_state : S_SCROLL_CP;
			end
			S_PUT: state_next = S_DONE;
			S_TAB: begin
				if (tab_stop) begin
					state_next = S_DONE;
				end
			end
			S_SCROLL_CP: begin
				if (ptr_q == LAST_CELL) begin
					state_next = S_SCROLL_DR;
				end
			end
			S_SCROLL_DR: state_next = S_SCROLL_BL;
			S_SCROLL_BL: begin
				if (ptr_q == LAST_CELL) begin
					state_next = resume_state;
				end
			end
			S_CLEAR: begin
				if (ptr_q == LAST_CELL) begin
					state_next = S_DONE;
				end
			end
			S_READ: state_next = S_DONE;
			S_DONE: begin
				if (out_load) begin
					state_next = S_IDLE;
				end
			end
			default: state_next = S_IDLE;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cursor_idx;
		mem_wdata = {attr_q, BLANK_CHAR};
		mem_re    = 1'b0;
		mem_raddr = ptr_q;
		q_pop     = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			S_INIT, S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q;
				mem_wdata = {DEFAULT_ATTR, BLANK_CHAR};
			end
			S_IDLE: q_pop = q_valid;
			S_PUT: begin
				mem_we    = 1'b1;
				mem_wdata = {attr_q, ch_q};
			end
			S_TAB: mem_we = ~at_edge;
			S_SCROLL_CP: mem_re = 1'b1;
			S_SCROLL_BL: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q;
			end
			S_READ: begin
				mem_re    = 1'b1;
				mem_raddr = addr_q;
			end
			S_DONE: out_load = ~out_valid_q | ~out_stall;
			default: begin
			end
		endcase
		// Second half of a row copy: the cell read in the cycle before lands a row up.
		if (pend_s1) begin
			mem_we    = 1'b1;
			mem_waddr = waddr_s1;
			mem_wdata = rdata_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			row_q       <= '0;
			col_q       <= '0;
			row_base_q  <= '0;
			attr_q      <= DEFAULT_ATTR;
			ptr_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			pend_s1 <= (state_q == S_SCROLL_CP);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.we) begin
				attr_q <= cfg.data;
			end
			case (state_q)
				S_INIT: ptr_q <= ptr_q + 1'b1;
				S_CLEAR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == LAST_CELL) begin
						row_q      <= '0;
						col_q      <= '0;
						row_base_q <= '0;
						attr_q     <= DEFAULT_ATTR;
					end
				end
				S_IDLE: begin
					if (q_valid && q_cmd.op == OP_CLEAR) begin
						ptr_q <= '0;
					end
				end
				S_RETURN: col_q <= '0;
				S_NEWLINE: begin
					col_q <= '0;
					if (row_q < ROW_LAST) begin
						row_q      <= row_q + 1'b1;
						row_base_q <= row_base_q + ROW_STEP;
					end else begin
						ptr_q <= ROW_STEP;
					end
				end
				S_PUT: col_q <= col_q + 1'b1;
				S_TAB: begin
					if (!at_edge) begin
						col_q <= col_q + 1'b1;
					end
				end
				S_SCROLL_CP: begin
					ptr_q <= (ptr_q == LAST_CELL) ? LAST_ROW_BASE : ptr_q + 1'b1;
				end
				S_SCROLL_BL: ptr_q <= ptr_q + 1'b1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= ptr_q - ROW_STEP;
		if (q_pop) begin
			op_q       <= q_cmd.op;
			ch_q       <= q_cmd.char_code;
			addr_q     <= q_cmd.addr;
			addr_ok_q  <= q_cmd.addr_ok;
			scrolled_q <= 1'b0;
		end else if (state_q == S_SCROLL_BL) begin
			scrolled_q <= 1'b1;
		end
		if (out_load) begin
			out_cell_q <= (op_q == OP_READ && addr_ok_q) ? rdata_q : '0;
			out_row_q  <= row_q;
			out_col_q  <= col_q;
			out_scr_q  <= scrolled_q;
		end
	end

	assign status.init_busy = (state_q == S_INIT);
	assign status.attr      = attr_q;

	assign out_valid  = out_valid_q;
	assign cell_value = out_cell_q;
	assign cursor_row = out_row_q;
	assign cursor_col = out_col_q;
	assign scrolled   = out_scr_q;

endmodule

/* rtl/core/text_console_writer.sv */
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console engine
// Screen store of character and attribute cells with a cursor, fed by items.
// ----------------------------------------------------------------------------
// The block keeps an 80 by 25 screen of 16-bit cells (character in the low
// byte, attribute in the high byte) in one on-chip memory and returns exactly
// one result item for every input item. After reset the memory is swept to
// blanks, one cell a cycle, and in_stall stays high throughout; configuration
// writes are still taken. The screen memory has a single write port, which
// takes one cell a cycle. A new line on the bottom row scrolls: every row
// below the top is read and written one row up through that same port, then
// the bottom row is blanked. A clear item sweeps the whole memory and also
// restores the attribute to its default. A two-entry queue sits between the
// input side and the executing side, and the result sits in an output
// register, so the next item can be taken while the previous result still
// waits.
// ----------------------------------------------------------------------------
module text_console_writer (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [7:0]  char_code,
	input  logic [10:0] cell_address,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] cell_value,
	output logic [4:0]  cursor_row,
	output logic [6:0]  cursor_col,
	output logic        scrolled,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [tcw_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [tcw_pkg::APB_DATA_W-1:0] pwdata,
	output logic [tcw_pkg::APB_DATA_W-1:0] prdata,
	output logic        pready
);
	import tcw_pkg::*;

	cmd_t         push_cmd;
	cmd_t         head_cmd;
	logic         q_push;
	logic         q_pop;
	logic         q_valid;
	logic         q_full;
	cfg_wr_t      cfg;
	back_status_t status;
	logic         reg_hit;

	// The register file has one entry, the attribute, at word address zero.
	// The word index is the top address bit; the byte offset is ignored.
	assign reg_hit  = (paddr[APB_ADDR_W-1] == REG_ATTR);
	assign pready   = 1'b1;
	assign cfg.we   = psel & penable & pwrite & pready & reg_hit;
	assign cfg.data = pwdata[ATTR_W-1:0];
	assign prdata   = reg_hit ? APB_DATA_W'(status.attr) : '0;

	// The front decodes each item into a command: a put is split into the
	// newline, return, tab and plain character cases, reads carry a range flag.
	tcw_front u_front (
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.char_code    (char_code),
		.cell_address (cell_address),
		.status       (status),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_cmd        (push_cmd)
	);

	tcw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.valid    (q_valid),
		.full     (q_full),
		.head_cmd (head_cmd)
	);

	// The back carries out one command at a time: cursor moves, cell writes,
	// scroll copies and clear sweeps, then loads the result register.
	tcw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_cmd      (head_cmd),
		.q_pop      (q_pop),
		.cfg        (cfg),
		.status     (status),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cell_value (cell_value),
		.cursor_row (cursor_row),
		.cursor_col (cursor_col),
		.scrolled   (scrolled)
	);

endmodule

/* rtl/core/tcw_checker.sv */
// ----------------------------------------------------------------------------
// tcw_checker: port-level checks of the text console writer
// Watches the result channel and the reported cursor over time.
// ----------------------------------------------------------------------------
module tcw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [4:0]  cursor_row,
	input logic [6:0]  cursor_col,
	input logic        scrolled
);
	import tcw_pkg::*;

	// A result item waiting on a stall is still offered in the next cycle.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result item dropped while stalled");

	// The cursor never leaves the screen; the column may sit at the edge.
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cursor_row < ROW_W'(SCREEN_HEIGHT))
			&& (cursor_col <= COL_W'(SCREEN_WIDTH)))
		else $error("cursor outside the screen");

	// A scroll only ever happens with the cursor left on the bottom row.
	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && scrolled |-> cursor_row == ROW_W'(SCREEN_HEIGHT - 1))
		else $error("scroll reported away from the bottom row");

	// After a scroll the cursor is near the left edge: at most one tab stop in.
	a_scroll_col: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && scrolled |-> cursor_col <= COL_W'(4))
		else $error("scroll left the cursor far from the left edge");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the text console writer
// Puts, reads, clears and unused-mode items go in over a valid/stall channel,
// with the attribute register written over APB between phases. A shadow of the
// screen store and cursor predicts every result item, which is then compared
// field by field as it leaves the block.
// ----------------------------------------------------------------------------

import tcw_pkg::*;

typedef struct packed {
	logic [CELL_W-1:0] cell_data;
	logic [ROW_W-1:0]  row;
	logic [COL_W-1:0]  col;
	logic              scrolled;
} console_report_t;

// Shadow copy of the screen, cursor and attribute, with the reports still owed.
class screen_shadow;
	localparam int TAB_STOP   = 4;
	localparam int REPORT_CAP = 40;

	logic [CELL_W-1:0] cells [CELL_COUNT];
	logic [ROW_W-1:0]  cur_row;
	logic [COL_W-1:0]  cur_col;
	logic [ATTR_W-1:0] attr;
	console_report_t   awaited [$];
	int                errors;
	int                checked;
	int                scrolls;
	int                reads;

	function new();
		errors  = 0;
		checked = 0;
		scrolls = 0;
		reads   = 0;
		blank_all();
	endfunction

	function void blank_all();
		foreach (cells[i])
			cells[i] = {DEFAULT_ATTR, BLANK_CHAR};
		cur_row = '0;
		cur_col = '0;
		attr    = DEFAULT_ATTR;
	endfunction

	function void set_attribute(logic [ATTR_W-1:0] value);
		attr = value;
	endfunction

	function void write_cell(logic [CHAR_W-1:0] ch);
		int idx;
		idx = int'(cur_row) * SCREEN_WIDTH + int'(cur_col);
		if (idx < CELL_COUNT)
			cells[idx] = {attr, ch};
		cur_col++;
	endfunction

	// Returns 1 when the move to the next row forced a scroll.
	function logic line_feed();
		cur_col = '0;
		if (int'(cur_row) < SCREEN_HEIGHT - 1) begin
			cur_row++;
			return 1'b0;
		end
		for (int i = SCREEN_WIDTH; i < CELL_COUNT; i++)
			cells[i - SCREEN_WIDTH] = cells[i];
		for (int i = CELL_COUNT - SCREEN_WIDTH; i < CELL_COUNT; i++)
			cells[i] = {attr, BLANK_CHAR};
		return 1'b1;
	endfunction

	function void note_item(logic [MODE_W-1:0] m, logic [CHAR_W-1:0] c,
			logic [ADDR_W-1:0] a);
		console_report_t want;
		int              pads;
		want = '0;
		case (m)
			MODE_PUT: begin
				if (c == CH_NEWLINE) begin
					want.scrolled = line_feed();
				end else if (c == CH_RETURN) begin
					cur_col = '0;
				end else if (c == CH_TAB) begin
					if (int'(cur_col) >= SCREEN_WIDTH)
						want.scrolled = line_feed();
					pads = TAB_STOP - int'(cur_col) % TAB_STOP;
					while (pads != 0 && int'(cur_col) < SCREEN_WIDTH) begin
						write_cell(BLANK_CHAR);
						pads--;
					end
				end else begin
					if (int'(cur_col) >= SCREEN_WIDTH)
						want.scrolled = line_feed();
					write_cell(c);
				end
			end
			MODE_READ: begin
				reads++;
				if (int'(a) < CELL_COUNT)
					want.cell_data = cells[a];
			end
			MODE_CLEAR: begin
				blank_all();
			end
			default: begin
			end
		endcase
		want.row = cur_row;
		want.col = cur_col;
		if (want.scrolled)
			scrolls++;
		awaited.push_back(want);
	endfunction

	function void mismatch(string field, int unsigned want_v, int unsigned got_v);
		errors++;
		if (errors <= REPORT_CAP)
			$error("%s: expected 0x%0h, got 0x%0h", field, want_v, got_v);
	endfunction

	function void check_report(logic [CELL_W-1:0] got_cell, logic [ROW_W-1:0] row,
			logic [COL_W-1:0] col, logic sc);
		console_report_t want;
		checked++;
		if (awaited.size() == 0) begin
			errors++;
			if (errors <= REPORT_CAP)
				$error("result item with no input item outstanding");
			return;
		end
		want = awaited.pop_front();
		if (got_cell !== want.cell_data)
			mismatch("cell_value", want.cell_data, got_cell);
		if (row !== want.row)
			mismatch("cursor_row", want.row, row);
		if (col !== want.col)
			mismatch("cursor_col", want.col, col);
		if (sc !== want.scrolled)
			mismatch("scrolled", want.scrolled, sc);
	endfunction

	function int pending();
		return awaited.size();
	endfunction
endclass

module testbench;

	// Mode 3 has no meaning in the block; it must leave everything untouched.
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam logic [APB_ADDR_W-1:0] ATTR_ADDR = APB_ADDR_W'(4 * int'(REG_ATTR));

	// A scroll or a clear walks the whole store, and so does the sweep after
	// reset, so the quiet limit sits well above the length of such a walk.
	localparam int QUIET_LIMIT = 20000;
	localparam int TAIL_CYCLES = 40;
	localparam int PHASE_ITEMS = 610;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [MODE_W-1:0]     mode;
	logic [CHAR_W-1:0]     char_code;
	logic [ADDR_W-1:0]     cell_address;
	logic                  out_valid;
	logic                  out_stall;
	logic [CELL_W-1:0]     cell_value;
	logic [ROW_W-1:0]      cursor_row;
	logic [COL_W-1:0]      cursor_col;
	logic                  scrolled;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	screen_shadow shadow;

	// Percentages of cycles in which the sender holds back and the receiver stalls.
	int gap_pct;
	int stall_pct;
	// Items that the block acts on (the unused mode is not counted).
	int items_sent;
	int clears_sent;

	text_console_writer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.char_code    (char_code),
		.cell_address (cell_address),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cell_value   (cell_value),
		.cursor_row   (cursor_row),
		.cursor_col   (cursor_col),
		.scrolled     (scrolled),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// The receiver stalls at random; the rate changes from phase to phase.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Every result item that leaves the block is checked against the oldest
	// prediction. The stall is read before this edge's update lands, so the
	// handshake seen here is the one the block saw.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			shadow.check_report(cell_value, cursor_row, cursor_col, scrolled);
	end

	// Watchdog: any handshake on either side counts as progress.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	// An APB write: a setup phase, then an access phase held until pready.
	task automatic write_attribute(input logic [ATTR_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ATTR_ADDR;
		pwdata  <= APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		shadow.set_attribute(value);
	endtask

	// Offers one item and returns in the time step in which it was taken.
	// Valid only drops when the sender really idles, so an item that follows
	// straight on keeps valid high without a glitch.
	task automatic send_item(input logic [MODE_W-1:0] m, input logic [CHAR_W-1:0] c,
			input logic [ADDR_W-1:0] a);
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		mode         <= m;
		char_code    <= c;
		cell_address <= a;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		shadow.note_item(m, c, a);
		if (m != MODE_UNUSED)
			items_sent++;
		if (m == MODE_CLEAR)
			clears_sent++;
	endtask

	// The address field is ignored on a put, so it carries random bits.
	task automatic put_char(input logic [CHAR_W-1:0] c);
		send_item(MODE_PUT, c, ADDR_W'($urandom_range(0, 2047)));
	endtask

	task automatic read_cell(input int a);
		send_item(MODE_READ, CHAR_W'($urandom_range(0, 255)), ADDR_W'(a));
	endtask

	// A byte that is written to the screen rather than acted on as a control.
	function automatic logic [CHAR_W-1:0] printable();
		logic [CHAR_W-1:0] c;
		c = CHAR_W'($urandom_range(0, 255));
		if (c == CH_TAB || c == CH_NEWLINE || c == CH_RETURN)
			c = BLANK_CHAR;
		return c;
	endfunction

	// Holds the sender back until every outstanding result has come out.
	task automatic pause_until_drained();
		in_valid <= 1'b0;
		while (shadow.pending() != 0)
			@(posedge clk);
	endtask

	task automatic directed_items();
		// Extremes of the character byte, then both tab widths from columns
		// three and four, a return and a newline.
		put_char(8'h41);
		put_char(8'h00);
		put_char(8'hFF);
		put_char(CH_TAB);
		put_char(CH_TAB);
		put_char(CH_RETURN);
		put_char(CH_NEWLINE);
		put_char(8'h80);
		// Reads of written cells, the last cell, and addresses past the store.
		read_cell(0);
		read_cell(3);
		read_cell(SCREEN_WIDTH);
		read_cell(CELL_COUNT - 1);
		read_cell(CELL_COUNT);
		read_cell(2047);
		// The unused mode with every field bit high must change nothing.
		send_item(MODE_UNUSED, 8'hFF, 11'h7FF);
		read_cell(1);
		// A clear homes the cursor and puts the attribute back to its default.
		send_item(MODE_CLEAR, 8'h00, 11'h000);
		read_cell(0);
		put_char(8'h7E);
		read_cell(0);
	endtask

	// Ordinary text ending mostly in a newline, sometimes a return alone.
	task automatic text_line();
		int len;
		int tail;
		len = $urandom_range(0, 24);
		repeat (len) begin
			if ($urandom_range(0, 6) == 0)
				put_char(CH_TAB);
			else
				put_char(printable());
		end
		tail = $urandom_range(0, 9);
		if (tail < 6) begin
			put_char(CH_NEWLINE);
		end else if (tail < 8) begin
			put_char(CH_RETURN);
			put_char(CH_NEWLINE);
		end else if (tail == 8) begin
			put_char(CH_RETURN);
		end
	endtask

	// Fills the row until a wrap is pending, then follows with whichever
	// item is picked: a tab or a character there wraps first.
	task automatic long_line();
		int tail;
		while (int'(shadow.cur_col) < SCREEN_WIDTH) begin
			if ($urandom_range(0, 7) == 0)
				put_char(CH_TAB);
			else
				put_char(printable());
		end
		tail = $urandom_range(0, 5);
		case (tail)
			0, 1: put_char(CH_TAB);
			2:    put_char(printable());
			3:    put_char(CH_NEWLINE);
			4:    put_char(CH_RETURN);
			default: read_cell(int'(shadow.cur_row) * SCREEN_WIDTH + SCREEN_WIDTH - 1);
		endcase
	endtask

	// Reads aimed mostly at the rows just written, a few past the store.
	task automatic read_burst();
		int n;
		int pick;
		int row;
		n = $urandom_range(1, 6);
		repeat (n) begin
			pick = $urandom_range(0, 9);
			row  = int'(shadow.cur_row);
			if (pick < 5)
				read_cell(row * SCREEN_WIDTH + $urandom_range(0, SCREEN_WIDTH - 1));
			else if (pick < 8)
				read_cell($urandom_range(0, CELL_COUNT - 1));
			else if (pick == 8)
				read_cell((row > 0 ? row - 1 : 0) * SCREEN_WIDTH
						+ $urandom_range(0, SCREEN_WIDTH - 1));
			else
				read_cell($urandom_range(CELL_COUNT, 2047));
		end
	endtask

	// Unused-mode items and stray controls that break up the text.
	task automatic noise_burst();
		int n;
		n = $urandom_range(1, 3);
		repeat (n) begin
			case ($urandom_range(0, 3))
				0, 1: send_item(MODE_UNUSED, CHAR_W'($urandom_range(0, 255)),
						ADDR_W'($urandom_range(0, 2047)));
				2:    put_char(CH_RETURN);
				default: put_char(CH_TAB);
			endcase
		end
	endtask

	// Clears are kept rare so that the cursor often reaches the bottom row
	// and newlines and wraps there scroll the screen.
	task automatic random_phase(input int quota);
		int goal;
		int pick;
		goal = items_sent + quota;
		while (items_sent < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 48)
				text_line();
			else if (pick < 56)
				long_line();
			else if (pick < 84)
				read_burst();
			else if (pick < 97)
				noise_burst();
			else if (pick < 98)
				send_item(MODE_CLEAR, CHAR_W'($urandom_range(0, 255)),
						ADDR_W'($urandom_range(0, 2047)));
			else
				pause_until_drained();
		end
	endtask

	initial begin
		// Every input has a known value from time zero; reset is held low.
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		mode         = MODE_PUT;
		char_code    = '0;
		cell_address = '0;
		out_stall    = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		items_sent   = 0;
		clears_sent  = 0;
		gap_pct      = 12;
		stall_pct    = 76;
		shadow       = new();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The register is taken even while the store is swept after reset.
		// The directed items before the clear run under the top attribute value.
		write_attribute(8'hFF);
		directed_items();

		// First phase: the sender rarely idles and the receiver mostly stalls.
		pause_until_drained();
		write_attribute(8'h00);
		random_phase(PHASE_ITEMS);

		// Second phase: the other way round.
		pause_until_drained();
		gap_pct   = 76;
		stall_pct = 12;
		write_attribute(ATTR_W'($urandom_range(1, 254)));
		random_phase(PHASE_ITEMS);

		// Last phase: both sides run flat out.
		pause_until_drained();
		gap_pct   = 0;
		stall_pct = 0;
		write_attribute(ATTR_W'($urandom_range(0, 255)));
		random_phase(PHASE_ITEMS);

		// Wait for the last results, then a little longer so that any stray
		// result item would still be caught.
		pause_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Checked %0d results for %0d items (%0d reads) under three idling mixes.",
				shadow.checked, items_sent, shadow.reads);
		$display("The screen scrolled %0d times and was cleared %0d times.",
				shadow.scrolls, clears_sent);
		if (shadow.errors == 0 && shadow.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
